/* design/assert_macros.svh */
// Assertion macros shared by the AT command recognizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every rising clock edge outside reset.
`define AT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("AT command recognizer: assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define AT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("AT command recognizer: assertion failed");

`endif

/* design/atcr_pkg.sv */
// Package with types, codes and name tables of the AT command recognizer.
`default_nettype none

package atcr_pkg;

    localparam int DEF_KEY_LEN   = 8;
    localparam int DEF_VALUE_LEN = 16;
    localparam int VALUE_LEN_MAX = 32;

    // Width of a stored value length; covers the whole value length range.
    localparam int LEN_W   = $clog2(VALUE_LEN_MAX + 1);
    localparam int NUM_CMDS = 3;
    localparam int POS_W   = 6;

    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_EQ   = 8'h3D;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_MALFORMED   = 2'd1,
        STATUS_UNKNOWN     = 2'd2,
        STATUS_UNSUPPORTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_VER   = 2'd0,
        CMD_CALIB = 2'd1,
        CMD_FEED  = 2'd2
    } cmd_id_t;

    // One finished message waiting for the back end.
    typedef struct packed {
        status_t            status;
        cmd_id_t            command_id;
        logic               is_set;
        logic [LEN_W-1:0]   value_length;
    } entry_t;

    // Occupancy and slot pointers of the verdict queue.
    typedef struct packed {
        logic empty;
        logic full;
        logic head_slot;
        logic tail_slot;
    } q_status_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_VALUE = 1'b1
    } back_state_t;

    function automatic logic [2:0] cmd_len(input logic [1:0] id);
        logic [2:0] len;
        unique case (id)
            CMD_VER:   len = 3'd3;
            CMD_CALIB: len = 3'd5;
            CMD_FEED:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic cmd_settable(input logic [1:0] id);
        return (id == CMD_CALIB);
    endfunction

    function automatic logic [7:0] cmd_char(input logic [1:0] id, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (id)
            CMD_VER:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h56;
                    3'd1:    ch = 8'h45;
                    3'd2:    ch = 8'h52;
                    default: ch = 8'h00;
                endcase
            end
            CMD_CALIB:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h43;
                    3'd1:    ch = 8'h41;
                    3'd2:    ch = 8'h4C;
                    3'd3:    ch = 8'h49;
                    3'd4:    ch = 8'h42;
                    default: ch = 8'h00;
                endcase
            end
            CMD_FEED:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h46;
                    3'd1:    ch = 8'h45;
                    3'd2:    ch = 8'h45;
                    3'd3:    ch = 8'h44;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* design/atcr_intf.sv */
// Handshake channel interfaces for message bytes and result items.
`default_nettype none

interface atcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface atcr_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] status;
    logic [1:0] command_id;
    logic       is_set;
    logic [4:0] value_length;
    logic [7:0] value_byte;
    logic       run_end;

    modport source (output valid, kind, status, command_id, is_set, value_length,
                    value_byte, run_end, input ready);
    modport sink   (input valid, kind, status, command_id, is_set, value_length,
                    value_byte, run_end, output ready);
endinterface

`default_nettype wire

/* design/atcr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module atcr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/atcr_queue.sv */
// Two-entry verdict queue between the parsing front end and the emitting back end.
`default_nettype none
`include "assert_macros.svh"

module atcr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire atcr_pkg::entry_t   push_entry,
    input  wire logic               pop,
    output atcr_pkg::entry_t        head_entry,
    output atcr_pkg::q_status_t     q_stat
);

    import atcr_pkg::*;

    entry_t      slot_reg [2];
    logic        head_reg;
    logic        head_next;
    logic        tail_reg;
    logic        tail_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = ~tail_reg;
        end
        if (pop)
        begin
            head_next = ~head_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_entry;
        end
    end

    assign head_entry       = slot_reg[head_reg];
    assign q_stat.empty     = (count_reg == 2'd0);
    assign q_stat.full      = (count_reg == 2'd2);
    assign q_stat.head_slot = head_reg;
    assign q_stat.tail_slot = tail_reg;

    // The slot pointers double as value memory banks, so overrun would corrupt values.
    `AT_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, count_reg != 2'd2)
    `AT_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, count_reg != 2'd0)
    `AT_ASSERT_NEXT(a_last_pop_empties, clk, rst_n, pop && !push && count_reg == 2'd1,
                    count_reg == 2'd0 && head_reg == tail_reg)

endmodule

`default_nettype wire

/* design/atcr_front.sv */
// Front end: accepts message bytes, checks syntax, matches the key and stores the value.
`default_nettype none

module atcr_front #(
    parameter int KEY_LEN   = atcr_pkg::DEF_KEY_LEN,
    parameter int VALUE_LEN = atcr_pkg::DEF_VALUE_LEN,
    parameter int IDX_W     = (VALUE_LEN > 1) ? $clog2(VALUE_LEN) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    atcr_in_if.sink                  cmd_in,
    input  wire atcr_pkg::q_status_t q_stat,
    output logic                     push,
    output atcr_pkg::entry_t         push_entry,
    output logic                     wr_en,
    output logic [IDX_W:0]           wr_addr,
    output logic [7:0]               wr_data
);

    import atcr_pkg::*;

    localparam int SEG_MAX   = (KEY_LEN > VALUE_LEN) ? KEY_LEN : VALUE_LEN;
    localparam int SEG_W     = $clog2(SEG_MAX + 1);
    localparam int MAX_TOTAL = 3 + KEY_LEN + 1 + VALUE_LEN;

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                in_value_reg;
    logic                in_value_next;
    logic [SEG_W-1:0]    seg_reg;
    logic [SEG_W-1:0]    seg_next;
    logic [NUM_CMDS-1:0] flags_reg;
    logic [NUM_CMDS-1:0] flags_next;
    logic                mal_reg;
    logic                mal_next;

    logic                accept;
    logic                mal_v;
    logic                inval_v;
    logic [SEG_W-1:0]    seg_v;
    logic [NUM_CMDS-1:0] flags_v;
    logic [1:0]          found_id;
    logic                found_any;

    assign cmd_in.ready = !q_stat.full;
    assign accept       = cmd_in.valid && cmd_in.ready;
    assign wr_data      = cmd_in.data_byte;
    assign wr_addr      = {q_stat.tail_slot, seg_reg[IDX_W-1:0]};

    always_comb
    begin
        pos_next      = pos_reg;
        in_value_next = in_value_reg;
        seg_next      = seg_reg;
        flags_next    = flags_reg;
        mal_next      = mal_reg;
        mal_v         = mal_reg;
        inval_v       = in_value_reg;
        seg_v         = seg_reg;
        flags_v       = flags_reg;
        found_id      = CMD_VER;
        found_any     = 1'b0;
        wr_en         = 1'b0;
        push          = 1'b0;
        push_entry    = '{status: STATUS_MALFORMED, command_id: CMD_VER, is_set: 1'b0,
                          value_length: '0};

        if (accept)
        begin
            if (pos_reg == POS_W'(0) && cmd_in.data_byte != CH_A)    mal_v = 1'b1;
            if (pos_reg == POS_W'(1) && cmd_in.data_byte != CH_T)    mal_v = 1'b1;
            if (pos_reg == POS_W'(2) && cmd_in.data_byte != CH_PLUS) mal_v = 1'b1;
            if (pos_reg == POS_W'(3) && cmd_in.data_byte == CH_EQ)   mal_v = 1'b1;
            if (pos_reg >= POS_W'(MAX_TOTAL))                         mal_v = 1'b1;

            if (pos_reg >= POS_W'(3))
            begin
                priority if (!in_value_reg && cmd_in.data_byte == CH_EQ)
                begin
                    // The first '=' closes the key: only exact-length names survive.
                    for (int i = 0; i < NUM_CMDS; i++)
                    begin
                        if (seg_reg != SEG_W'(cmd_len(2'(i))))
                        begin
                            flags_v[i] = 1'b0;
                        end
                    end
                    inval_v = 1'b1;
                    seg_v   = '0;
                end
                else if (in_value_reg)
                begin
                    if (seg_reg < SEG_W'(VALUE_LEN))
                    begin
                        wr_en = 1'b1;
                        seg_v = seg_reg + SEG_W'(1);
                    end
                    else
                    begin
                        mal_v = 1'b1;
                    end
                end
                else
                begin
                    if (seg_reg < SEG_W'(KEY_LEN))
                    begin
                        for (int i = 0; i < NUM_CMDS; i++)
                        begin
                            if (seg_reg >= SEG_W'(cmd_len(2'(i))) ||
                                cmd_char(2'(i), seg_reg[2:0]) != cmd_in.data_byte)
                            begin
                                flags_v[i] = 1'b0;
                            end
                        end
                        seg_v = seg_reg + SEG_W'(1);
                    end
                    else
                    begin
                        mal_v = 1'b1;
                    end
                end
            end

            if (pos_reg != {POS_W{1'b1}})
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            in_value_next = inval_v;
            seg_next      = seg_v;
            flags_next    = flags_v;
            mal_next      = mal_v;

            if (cmd_in.last_byte)
            begin
                if (pos_reg < POS_W'(3))       mal_v = 1'b1;
                if (inval_v && seg_v == '0)    mal_v = 1'b1;
                if (!inval_v)
                begin
                    for (int i = 0; i < NUM_CMDS; i++)
                    begin
                        if (seg_v != SEG_W'(cmd_len(2'(i))))
                        begin
                            flags_v[i] = 1'b0;
                        end
                    end
                end

                priority if (flags_v[0])
                begin
                    found_any = 1'b1;
                    found_id  = CMD_VER;
                end
                else if (flags_v[1])
                begin
                    found_any = 1'b1;
                    found_id  = CMD_CALIB;
                end
                else if (flags_v[2])
                begin
                    found_any = 1'b1;
                    found_id  = CMD_FEED;
                end
                else
                begin
                    found_any = 1'b0;
                end

                push = 1'b1;
                priority if (mal_v)
                begin
                    push_entry.status = STATUS_MALFORMED;
                end
                else if (!found_any)
                begin
                    push_entry.status = STATUS_UNKNOWN;
                    push_entry.is_set = inval_v;
                end
                else if (inval_v && !cmd_settable(found_id))
                begin
                    push_entry.status = STATUS_UNSUPPORTED;
                    push_entry.is_set = 1'b1;
                end
                else
                begin
                    push_entry.status       = STATUS_OK;
                    push_entry.command_id   = cmd_id_t'(found_id);
                    push_entry.is_set       = inval_v;
                    push_entry.value_length = inval_v ? LEN_W'(seg_v) : '0;
                end

                pos_next      = '0;
                in_value_next = 1'b0;
                seg_next      = '0;
                flags_next    = '1;
                mal_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            in_value_reg <= 1'b0;
            seg_reg      <= '0;
            flags_reg    <= '1;
            mal_reg      <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            in_value_reg <= in_value_next;
            seg_reg      <= seg_next;
            flags_reg    <= flags_next;
            mal_reg      <= mal_next;
        end
    end

endmodule

`default_nettype wire

/* design/atcr_back.sv */
// Back end: emits the verdict of each queued message, then its buffered value bytes.
`default_nettype none
`include "assert_macros.svh"

module atcr_back #(
    parameter int VALUE_LEN = atcr_pkg::DEF_VALUE_LEN,
    parameter int IDX_W     = (VALUE_LEN > 1) ? $clog2(VALUE_LEN) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire atcr_pkg::q_status_t q_stat,
    input  wire atcr_pkg::entry_t    head_entry,
    output logic                     pop,
    output logic                     rd_en,
    output logic [IDX_W:0]           rd_addr,
    input  wire logic [7:0]          rd_data,
    atcr_out_if.source               res_out
);

    import atcr_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [LEN_W-1:0] idx_reg;
    logic [LEN_W-1:0] idx_next;
    logic [LEN_W-1:0] rd_idx;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             kind_reg;
    logic [1:0]       status_reg;
    logic [1:0]       command_id_reg;
    logic             is_set_reg;
    logic [4:0]       value_length_reg;
    logic [7:0]       value_byte_reg;
    logic             run_end_reg;

    logic             can_load;
    logic             last_value;
    logic             load_verdict;
    logic             load_value;

    assign can_load   = !out_valid_reg || res_out.ready;
    assign last_value = (idx_reg + LEN_W'(1)) == head_entry.value_length;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && can_load && head_entry.value_length != '0)
                begin
                    state_next = BK_VALUE;
                end
            end
            BK_VALUE:
            begin
                if (can_load && last_value)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // The memory read for the next value byte is issued in the cycle the
    // current result is loaded, so its data waits in the read register.
    always_comb
    begin
        load_verdict = 1'b0;
        load_value   = 1'b0;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_idx       = idx_reg;
        idx_next     = idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && can_load)
                begin
                    load_verdict = 1'b1;
                    if (head_entry.value_length == '0)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = '0;
                        idx_next = '0;
                    end
                end
            end
            BK_VALUE:
            begin
                if (can_load)
                begin
                    load_value = 1'b1;
                    if (last_value)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = idx_reg + LEN_W'(1);
                        idx_next = idx_reg + LEN_W'(1);
                    end
                end
            end
            default:
            begin
                load_verdict = 1'b0;
            end
        endcase
    end

    assign rd_addr = {q_stat.head_slot, rd_idx[IDX_W-1:0]};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_verdict || load_value)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_verdict)
        begin
            kind_reg         <= 1'b0;
            status_reg       <= head_entry.status;
            command_id_reg   <= head_entry.command_id;
            is_set_reg       <= head_entry.is_set;
            value_length_reg <= head_entry.value_length[4:0];
            value_byte_reg   <= 8'h00;
            run_end_reg      <= (head_entry.value_length == '0);
        end
        else if (load_value)
        begin
            kind_reg         <= 1'b1;
            status_reg       <= STATUS_OK;
            command_id_reg   <= head_entry.command_id;
            is_set_reg       <= 1'b1;
            value_length_reg <= head_entry.value_length[4:0];
            value_byte_reg   <= rd_data;
            run_end_reg      <= last_value;
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.kind         = kind_reg;
    assign res_out.status       = status_reg;
    assign res_out.command_id   = command_id_reg;
    assign res_out.is_set       = is_set_reg;
    assign res_out.value_length = value_length_reg;
    assign res_out.value_byte   = value_byte_reg;
    assign res_out.run_end      = run_end_reg;

    `AT_ASSERT_IMPL(a_value_needs_entry, clk, rst_n, state_reg == BK_VALUE, !q_stat.empty)
    `AT_ASSERT_IMPL(a_value_idx_in_range, clk, rst_n, state_reg == BK_VALUE,
                    idx_reg < head_entry.value_length)
    `AT_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid_reg && !res_out.ready, out_valid_reg)

endmodule

`default_nettype wire

/* design/at_command_recognizer.sv */
// On the last byte the verdict is queued, then registered onto the output when it is free.
// Value bytes of an ok set follow at one result per cycle when the sink is ready.
// Throughput: one message byte per cycle; input stalls only while two finished
// messages wait in the two-entry verdict queue, each holding one value memory bank.
// Reset clears all parser, queue and output control state; value memory is not cleared.
`default_nettype none

module at_command_recognizer #(
    parameter int KEY_LEN   = atcr_pkg::DEF_KEY_LEN,
    parameter int VALUE_LEN = atcr_pkg::DEF_VALUE_LEN
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    atcr_in_if.sink    cmd_in,
    atcr_out_if.source res_out
);

    import atcr_pkg::*;

    localparam int IDX_W     = (VALUE_LEN > 1) ? $clog2(VALUE_LEN) : 1;
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);

    q_status_t      q_stat;
    entry_t         push_entry;
    entry_t         head_entry;
    logic           push;
    logic           pop;
    logic           wr_en;
    logic [IDX_W:0] wr_addr;
    logic [7:0]     wr_data;
    logic           rd_en;
    logic [IDX_W:0] rd_addr;
    logic [7:0]     rd_data;

    atcr_front #(
        .KEY_LEN   (KEY_LEN),
        .VALUE_LEN (VALUE_LEN),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_in     (cmd_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    atcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    atcr_ram #(
        .WIDTH  (8),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (IDX_W + 1)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    atcr_back #(
        .VALUE_LEN (VALUE_LEN),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head_entry (head_entry),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_out    (res_out)
    );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the AT command recognizer: directed and random messages.
`timescale 1ns / 100ps

module testbench;
    import atcr_pkg::*;

    localparam int KEY_MAX     = DEF_KEY_LEN;
    localparam int VAL_MAX     = DEF_VALUE_LEN;
    localparam int MSG_MAX     = 3 + KEY_MAX + 1 + VAL_MAX;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 300;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic        kind;
        status_t     status;
        cmd_id_t     command_id;
        logic        is_set;
        logic [4:0]  value_length;
        logic [7:0]  value_byte;
        logic        run_end;
    } result_t;

    logic clk;
    logic rst_n;

    atcr_in_if  cmd_if ();
    atcr_out_if res_if ();

    at_command_recognizer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_if),
        .res_out (res_if)
    );

    // Parser state mirrored from the block.
    logic [5:0] msg_pos;
    logic       in_val;
    logic [4:0] seg_len;
    logic [2:0] cand;
    logic       bad;
    logic [7:0] val_mem [VAL_MAX];

    string cmd_names [3] = '{"VER", "CALIB", "FEED"};

    result_t    awaited_results [$];
    result_t    want;
    logic [7:0] msg_buf [$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int bytes_sent   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_token  = 0;
    int stall_seen   = 0;
    int hold_left    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test bumps the token.
    always @(negedge clk)
    begin
        if (stall_token != stall_seen)
        begin
            stall_seen = stall_token;
            hold_left  = LONG_STALL;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                         $time, res_if.kind, res_if.status);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", want.kind, res_if.kind);
                check_field("status", want.status, res_if.status);
                check_field("command_id", want.command_id, res_if.command_id);
                check_field("is_set", want.is_set, res_if.is_set);
                check_field("value_length", want.value_length, res_if.value_length);
                check_field("value_byte", want.value_byte, res_if.value_byte);
                check_field("run_end", want.run_end, res_if.run_end);
            end
        end
    end

    task automatic clear_parser();
        msg_pos = '0;
        in_val  = 1'b0;
        seg_len = '0;
        cand    = 3'b111;
        bad     = 1'b0;
    endtask

    // A finished key can only match names of exactly its length.
    function automatic logic [2:0] keep_same_length(input logic [2:0] c, input logic [4:0] n);
        logic [2:0] r;
        r = c;
        for (int i = 0; i < 3; i++)
            if (n != cmd_names[i].len())
                r[i] = 1'b0;
        return r;
    endfunction

    // Advances the parser by one accepted byte and queues the results it causes.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int         pos;
        int         found;
        status_t    st;
        cmd_id_t    id;
        logic       set;
        logic [4:0] vlen;
        result_t    r;

        pos = msg_pos;
        if (pos == 0 && b != CH_A)
            bad = 1'b1;
        if (pos == 1 && b != CH_T)
            bad = 1'b1;
        if (pos == 2 && b != CH_PLUS)
            bad = 1'b1;
        if (pos == 3 && b == CH_EQ)
            bad = 1'b1;
        if (pos + 1 > MSG_MAX)
            bad = 1'b1;

        if (pos >= 3)
        begin
            if (!in_val && b == CH_EQ)
            begin
                cand    = keep_same_length(cand, seg_len);
                in_val  = 1'b1;
                seg_len = '0;
            end
            else if (in_val)
            begin
                if (seg_len < VAL_MAX)
                begin
                    val_mem[seg_len] = b;
                    seg_len++;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            else
            begin
                if (seg_len < KEY_MAX)
                begin
                    for (int i = 0; i < 3; i++)
                        if (seg_len >= cmd_names[i].len() || cmd_names[i][seg_len] != b)
                            cand[i] = 1'b0;
                    seg_len++;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
        end

        if (msg_pos < 6'd63)
            msg_pos++;

        if (last)
        begin
            if (pos + 1 < 4)
                bad = 1'b1;
            if (in_val && seg_len == 0)
                bad = 1'b1;
            if (!in_val)
                cand = keep_same_length(cand, seg_len);

            found = -1;
            for (int i = 0; i < 3; i++)
                if (cand[i] && found < 0)
                    found = i;

            id   = CMD_VER;
            set  = 1'b0;
            vlen = '0;
            if (bad)
            begin
                st = STATUS_MALFORMED;
            end
            else if (found < 0)
            begin
                st  = STATUS_UNKNOWN;
                set = in_val;
            end
            else if (in_val && cmd_id_t'(found) != CMD_CALIB)
            begin
                st  = STATUS_UNSUPPORTED;
                set = 1'b1;
            end
            else
            begin
                st   = STATUS_OK;
                id   = cmd_id_t'(found);
                set  = in_val;
                vlen = in_val ? seg_len : 5'd0;
            end

            r = '{kind: 1'b0, status: st, command_id: id, is_set: set, value_length: vlen,
                  value_byte: 8'h00, run_end: (vlen == 0)};
            awaited_results.push_back(r);
            for (int i = 0; i < vlen; i++)
            begin
                r = '{kind: 1'b1, status: STATUS_OK, command_id: id, is_set: 1'b1,
                      value_length: vlen, value_byte: val_mem[i], run_end: (i + 1 == vlen)};
                awaited_results.push_back(r);
            end
            clear_parser();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.data_byte <= b;
        cmd_if.last_byte <= last;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        parse_byte(b, last);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_buf.push_back(s[i]);
    endtask

    task automatic put_byte(input logic [7:0] b);
        msg_buf.push_back(b);
    endtask

    task automatic put_random(input int n);
        repeat (n) msg_buf.push_back($urandom_range(0, 255));
    endtask

    task automatic send_msg();
        int n;
        n = msg_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_buf[i], i == n - 1);
        bytes_sent += n;
        msg_buf.delete();
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_msg();
    endtask

    task automatic test_valid_commands();
        send_text("AT+VER");
        send_text("AT+CALIB");
        send_text("AT+FEED");
        send_text("AT+CALIB=5");
        send_text("AT+CALIB==");
        send_text("AT+CALIB=a=b");
        // Longest value, with both extreme byte values inside it.
        put_text("AT+CALIB=");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_random(14);
        send_msg();
        send_text("AT+VER=1");
        send_text("AT+FEED=12");
        send_text("AT+FOO");
        send_text("AT+FOO=1");
        send_text("AT+CAL");
        send_text("AT+CALIBX");
        put_text("AT+FEE");
        put_byte(8'h00);
        send_msg();
        send_text("AT+ABCDEFGH");
        // Longest legal total length, on an unknown key.
        put_text("AT+ABCDEFGH=");
        put_random(16);
        send_msg();
    endtask

    task automatic test_malformed_messages();
        send_text("A");
        send_text("AT+");
        send_text("XT+VER");
        send_text("AX+VER");
        send_text("ATXVER");
        send_text("AT+=1");
        send_text("AT+CALIB=");
        send_text("AT+ABCDEFGHI");
        put_text("AT+CALIB=");
        put_random(17);
        send_msg();
        put_text("AT+ABCDEFGH=");
        put_random(17);
        send_msg();
        // Long enough to drive the position counter into saturation.
        put_text("AT+CALIB=");
        put_random(60);
        send_msg();
    endtask

    task automatic send_random_message();
        int         choice;
        int         vlen;
        int         k;
        logic [7:0] b;

        choice = $urandom_range(0, 99);
        if (choice < 70)
        begin
            put_text("AT+");
            case ($urandom_range(0, 5))
                0: put_text("VER");
                1: put_text("FEED");
                2, 3, 4: put_text("CALIB");
                default:
                begin
                    repeat ($urandom_range(1, 9))
                    begin
                        do
                            b = $urandom_range(0, 255);
                        while (b == CH_EQ);
                        put_byte(b);
                    end
                end
            endcase
            if ($urandom_range(0, 3) != 0)
            begin
                put_byte(CH_EQ);
                if ($urandom_range(0, 7) == 0)
                    vlen = $urandom_range(0, 17);
                else
                    vlen = $urandom_range(1, 6);
                put_random(vlen);
            end
        end
        else if (choice < 85)
        begin
            // A well-formed set with one byte overwritten at random.
            put_text("AT+CALIB=");
            put_random($urandom_range(1, 8));
            k = $urandom_range(0, msg_buf.size() - 1);
            msg_buf[k] = $urandom_range(0, 255);
        end
        else
        begin
            put_random($urandom_range(1, 34));
        end
        send_msg();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_bytes);
        int stop_at;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_message();
    endtask

    // The receiver holds off while the sender keeps going, so the verdict queue fills.
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_token++;
        repeat (4)
        begin
            put_text("AT+CALIB=");
            put_random($urandom_range(1, 6));
            send_msg();
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.data_byte = 8'h00;
        cmd_if.last_byte = 1'b0;
        res_if.ready     = 1'b0;
        clear_parser();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 32;
        snk_idle_pct = 50;
        test_valid_commands();
        test_malformed_messages();
        test_random_traffic(32, 50, 20);
        test_random_traffic(50, 32, 20);
        test_output_backpressure();
        test_random_traffic(0, 0, 20);

        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* at_command_recognizer.f */
+incdir+design
design/atcr_pkg.sv
design/atcr_intf.sv
design/atcr_ram.sv
design/atcr_queue.sv
design/atcr_front.sv
design/atcr_back.sv
design/at_command_recognizer.sv
tb/sv/testbench.sv
